>>> rtl/assert_macros.svh
// Assertion macros shared by the DNS query filter RTL.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every enabled clock edge.
`define DQF_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define DQF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dqf_pkg.sv
// Shared types and constants of the DNS query filter.
// Used by the parser front, the decision queue, the lookup back end and the top level.
`default_nettype none

package dqf_pkg;

   typedef enum logic [2:0] {
      VERDICT_NOT_IP      = 3'd0,
      VERDICT_BAD_VERSION = 3'd1,
      VERDICT_NOT_UDP     = 3'd2,
      VERDICT_NOT_DNS     = 3'd3,
      VERDICT_TRUNCATED   = 3'd4,
      VERDICT_DUPLICATE   = 3'd5,
      VERDICT_RESPOND     = 3'd6,
      VERDICT_IPV6_UNSENT = 3'd7
   } verdict_type;

   typedef enum logic [1:0] {
      CLASS_OTHER = 2'd0,
      CLASS_IPV4  = 2'd1,
      CLASS_IPV6  = 2'd2
   } pkt_class_type;

   localparam logic [15:0] DnsPortReset = 16'd53;
   localparam logic [7:0]  UdpProto     = 8'd17;
   localparam logic [5:0]  Ipv6HdrLen   = 6'd40;
   localparam logic [15:0] Ipv4ProtoPos = 16'd9;
   localparam logic [15:0] Ipv6ProtoPos = 16'd6;
   localparam logic [15:0] Ipv4AddrEnd  = 16'd19;
   localparam logic [15:0] Ipv4SrcStart = 16'd12;
   localparam logic [15:0] Ipv4DstStart = 16'd16;
   localparam logic [15:0] Ipv4DstEnd   = 16'd20;
   localparam logic [15:0] UdpPortsEnd  = 16'd3;
   localparam logic [15:0] UdpIdEnd     = 16'd9;
   localparam logic [15:0] OffsetMax    = 16'hFFFF;
   localparam logic [3:0]  IpVersion4   = 4'd4;
   localparam logic [3:0]  IpVersion6   = 4'd6;

   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // One decided packet on its way from the parser to the lookup stage.
   typedef struct packed {
      verdict_type verdict;
      logic        lookup;
      logic        is_v4;
      logic [15:0] query_id;
      logic [31:0] to_addr;
      logic [31:0] from_addr;
      logic [15:0] to_port;
      logic [15:0] from_port;
   } dqf_rec_type;

endpackage

`default_nettype wire

>>> rtl/dns_query_filter_with_dedupe.sv
// Top level of the DNS query filter with duplicate suppression.
// Instantiates dqf_front, dqf_queue and dqf_back; depends on dqf_pkg.
//
//   Port group   Direction   Transaction accepted when
//   req_*        in          req_push high and req_full low
//   rsp_*        out         rsp_pop high and rsp_empty low
//   csr_*        in          csr_write_enable high
//
// The parser takes one byte per cycle while req_full is low; a packet's verdict is decided on its
// last byte. With the lookup stage free, a non-query verdict passes through the decision queue
// and then the result register to the ports. A DNS query holds the lookup stage while the ids
// recorded so far (fill, at most RING_DEPTH) are read back one per cycle.
// req_full is high while the decision queue holds two packets, and the lookup stage takes no
// packet while a result waits. Reset clears the ring through its fill count, with no pass.
`default_nettype none

module dns_query_filter_with_dedupe
   import dqf_pkg::*;
#(
   parameter int RING_DEPTH = 50
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic [1:0]  req_frame_kind,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_verdict,
   output logic [15:0]      rsp_query_id,
   output logic [31:0]      rsp_reply_dest_addr,
   output logic [31:0]      rsp_reply_src_addr,
   output logic [15:0]      rsp_reply_dest_port,
   output logic [15:0]      rsp_reply_src_port,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   logic [15:0]  dns_port_ff;
   logic         accept, rec_push, q_full, q_empty, q_pop, rsp_valid;
   dqf_rec_type  rec, q_dout, rsp_rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         dns_port_ff <= DnsPortReset;
      end else if (csr_write_enable) begin
         dns_port_ff <= csr_write_data;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   dqf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .frame_kind (req_frame_kind),
      .dns_port   (dns_port_ff),
      .rec_push   (rec_push),
      .rec        (rec)
   );

   dqf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (rec_push),
      .din   (rec),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   dqf_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_dout    (q_dout),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_empty           = !rsp_valid;
   assign rsp_verdict         = rsp_rec.verdict;
   assign rsp_query_id        = rsp_rec.query_id;
   assign rsp_reply_dest_addr = rsp_rec.to_addr;
   assign rsp_reply_src_addr  = rsp_rec.from_addr;
   assign rsp_reply_dest_port = rsp_rec.to_port;
   assign rsp_reply_src_port  = rsp_rec.from_port;

endmodule

`default_nettype wire

>>> rtl/dqf_queue.sv
// Short queue of decided packets between the parser and the lookup stage.
// Depends on dqf_pkg for the record type and the queue depth.
`default_nettype none

module dqf_queue
   import dqf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire dqf_rec_type din,
   output logic             full,
   input  wire logic        pop,
   output dqf_rec_type      dout,
   output logic             empty
);

`include "assert_macros.svh"

   dqf_rec_type              entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]     count_ff, count_in;
   logic                     do_push, do_pop;

   always_comb begin
      full      = (count_ff == QueueCntW'(QueueDepth));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      dout = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

   `DQF_ASSERT_ALWAYS(a_count_bound, count_ff <= QueueCntW'(QueueDepth), "queue overfilled")
   `DQF_ASSERT_NEXT(a_push_only_count, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1,
      "push did not raise the count")
   `DQF_ASSERT_SAME(a_ptrs_meet, empty || full, wr_ptr_ff == rd_ptr_ff,
      "pointers disagree with the count")

endmodule

`default_nettype wire

>>> rtl/dqf_front.sv
// Byte parser: captures the IP and UDP fields of each packet and decides its verdict.
// Packets that need the duplicate check leave with the lookup flag set. Depends on dqf_pkg.
`default_nettype none

module dqf_front
   import dqf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  data_byte,
   input  wire logic        last_byte,
   input  wire logic [1:0]  frame_kind,
   input  wire logic [15:0] dns_port,
   output logic             rec_push,
   output dqf_rec_type      rec
);

`include "assert_macros.svh"

   logic [15:0]   off_ff, off_in;
   pkt_class_type cls_ff, cls_in;
   verdict_type   early_ff, early_in;
   logic [3:0]    hw_ff, hw_in;
   logic [7:0]    proto_ff, proto_in;
   logic [31:0]   saddr_ff, saddr_in;
   logic [31:0]   daddr_ff, daddr_in;
   logic [15:0]   sport_ff, sport_in;
   logic [15:0]   dport_ff, dport_in;
   logic [15:0]   id_ff, id_in;

   logic          first, v4, show_ports, show_id, show_addr;
   logic [3:0]    version;
   logic [5:0]    base;
   logic [15:0]   base16, proto_pos, rel, need;

   always_comb begin
      first   = (off_ff == '0);
      version = data_byte[7:4];

      cls_in   = cls_ff;
      hw_in    = hw_ff;
      early_in = early_ff;
      proto_in = proto_ff;
      saddr_in = saddr_ff;
      daddr_in = daddr_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;
      id_in    = id_ff;

      if (first) begin
         case (frame_kind)
            CLASS_IPV4: cls_in = CLASS_IPV4;
            CLASS_IPV6: cls_in = CLASS_IPV6;
            default:    cls_in = CLASS_OTHER;
         endcase
         hw_in    = data_byte[3:0];
         proto_in = '0;
         saddr_in = '0;
         daddr_in = '0;
         sport_in = '0;
         dport_in = '0;
         id_in    = '0;
         if (cls_in == CLASS_OTHER) begin
            early_in = VERDICT_NOT_IP;
         end else if (!(version inside {IpVersion4, IpVersion6})) begin
            early_in = VERDICT_BAD_VERSION;
         end else begin
            early_in = VERDICT_RESPOND;
         end
      end

      v4        = (cls_in == CLASS_IPV4);
      base      = v4 ? {hw_in, 2'b00} : Ipv6HdrLen;
      base16    = {10'd0, base};
      proto_pos = v4 ? Ipv4ProtoPos : Ipv6ProtoPos;
      rel       = off_ff - base16;

      if (off_ff == proto_pos) begin
         proto_in = data_byte;
      end
      if (v4 && off_ff >= Ipv4SrcStart && off_ff < Ipv4DstStart) begin
         saddr_in = {saddr_in[23:0], data_byte};
      end
      if (v4 && off_ff >= Ipv4DstStart && off_ff < Ipv4DstEnd) begin
         daddr_in = {daddr_in[23:0], data_byte};
      end
      if (off_ff >= base16) begin
         if (rel < 16'd2) begin
            sport_in = {sport_in[7:0], data_byte};
         end else if (rel < 16'd4) begin
            dport_in = {dport_in[7:0], data_byte};
         end else if (rel == 16'd8 || rel == 16'd9) begin
            id_in = {id_in[7:0], data_byte};
         end
      end

      if (last_byte) begin
         off_in = '0;
      end else if (off_ff != OffsetMax) begin
         off_in = off_ff + 1'b1;
      end else begin
         off_in = off_ff;
      end

      need = base16 + UdpIdEnd;
      if (v4 && need < Ipv4AddrEnd) begin
         need = Ipv4AddrEnd;
      end

      show_ports  = 1'b0;
      show_id     = 1'b0;
      show_addr   = 1'b0;
      rec.lookup  = 1'b0;
      rec.is_v4   = v4;
      if (early_in != VERDICT_RESPOND) begin
         rec.verdict = early_in;
      end else if (off_ff < proto_pos) begin
         rec.verdict = VERDICT_TRUNCATED;
      end else if (proto_in != UdpProto) begin
         rec.verdict = VERDICT_NOT_UDP;
      end else if (off_ff < base16 + UdpPortsEnd) begin
         rec.verdict = VERDICT_TRUNCATED;
      end else if (dport_in != dns_port) begin
         rec.verdict = VERDICT_NOT_DNS;
         show_ports  = 1'b1;
         show_addr   = v4;
      end else if (off_ff < need) begin
         rec.verdict = VERDICT_TRUNCATED;
      end else begin
         rec.verdict = VERDICT_RESPOND;
         rec.lookup  = 1'b1;
         show_ports  = 1'b1;
         show_id     = 1'b1;
         show_addr   = v4;
      end

      rec.query_id  = show_id ? id_in : '0;
      rec.to_addr   = show_addr ? saddr_in : '0;
      rec.from_addr = show_addr ? daddr_in : '0;
      rec.to_port   = show_ports ? sport_in : '0;
      rec.from_port = show_ports ? dport_in : '0;
      rec_push      = accept && last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         cls_ff   <= CLASS_OTHER;
         early_ff <= VERDICT_NOT_IP;
      end else if (accept) begin
         off_ff   <= off_in;
         cls_ff   <= cls_in;
         early_ff <= early_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hw_ff    <= hw_in;
         proto_ff <= proto_in;
         saddr_ff <= saddr_in;
         daddr_ff <= daddr_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
         id_ff    <= id_in;
      end
   end

   `DQF_ASSERT_NEXT(a_restart, accept && last_byte, off_ff == '0,
      "offset not cleared after the last byte")
   `DQF_ASSERT_SAME(a_lookup_port, rec_push && rec.lookup, rec.from_port == dns_port,
      "lookup requested for a packet off the DNS port")
   `DQF_ASSERT_SAME(a_lookup_class, rec_push && rec.lookup,
      cls_in == CLASS_IPV4 || cls_in == CLASS_IPV6, "lookup requested for a non-IP packet")

endmodule

`default_nettype wire

>>> rtl/dqf_back.sv
// Lookup stage: scans the ring of answered ids for each DNS query, records fresh IPv4
// answers and holds the result register. Depends on dqf_pkg.
`default_nettype none

module dqf_back
   import dqf_pkg::*;
#(
   parameter int RING_DEPTH = 50
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   input  wire dqf_rec_type q_dout,
   output logic             q_pop,
   input  wire logic        rsp_pop,
   output logic             rsp_valid,
   output dqf_rec_type      rsp_rec
);

`include "assert_macros.svh"

   localparam int AddrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CntW  = $clog2(RING_DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type         state_ff, state_in;
   logic [15:0]       ring_mem [RING_DEPTH];
   logic [15:0]       rdata_ff;
   logic              pend_ff, pend_in;
   logic              hit_ff, hit_in;
   logic [CntW-1:0]   idx_ff, idx_in;
   logic [CntW-1:0]   fill_ff, fill_in;
   logic [AddrW-1:0]  head_ff, head_in;
   dqf_rec_type       cur_ff, cur_in;
   dqf_rec_type       out_ff, out_in;
   logic              out_vld_ff, out_vld_in;
   logic              rd_en, respond, load;

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      hit_in     = hit_ff;
      idx_in     = idx_ff;
      pend_in    = 1'b0;
      fill_in    = fill_ff;
      head_in    = head_ff;
      out_in     = out_ff;
      load       = 1'b0;
      rd_en      = 1'b0;
      respond    = 1'b0;
      q_pop      = (state_ff == ST_IDLE) && !q_empty && !out_vld_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               cur_in = q_dout;
               if (q_dout.lookup) begin
                  // Entries past the fill count count as zero: a query id of zero hits while the ring is not full.
                  hit_in   = (q_dout.query_id == '0) && (fill_ff < CntW'(RING_DEPTH));
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  out_in = q_dout;
                  load   = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            hit_in = hit_ff || (pend_ff && rdata_ff == cur_ff.query_id);
            if (idx_ff < fill_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in  = ST_IDLE;
               load      = 1'b1;
               out_in    = cur_ff;
               if (hit_ff) begin
                  out_in.verdict = VERDICT_DUPLICATE;
               end else if (cur_ff.is_v4) begin
                  out_in.verdict = VERDICT_RESPOND;
                  respond        = 1'b1;
                  head_in        = (head_ff == AddrW'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  if (fill_ff < CntW'(RING_DEPTH)) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  out_in.verdict = VERDICT_IPV6_UNSENT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_vld_in = load || (out_vld_ff && !rsp_pop);
      rsp_valid  = out_vld_ff;
      rsp_rec    = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pend_ff    <= 1'b0;
         fill_ff    <= '0;
         head_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         fill_ff    <= fill_in;
         head_ff    <= head_in;
         out_vld_ff <= out_vld_in;
      end
      cur_ff <= cur_in;
      hit_ff <= hit_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (respond) begin
         ring_mem[head_ff] <= cur_ff.query_id;
      end
      if (rd_en) begin
         rdata_ff <= ring_mem[idx_ff[AddrW-1:0]];
      end
   end

   `DQF_ASSERT_ALWAYS(a_fill_bound, fill_ff <= CntW'(RING_DEPTH), "fill count past ring depth")
   `DQF_ASSERT_SAME(a_scan_index, state_ff == ST_SCAN, idx_ff <= fill_ff,
      "scan index ran past the fill count")
   `DQF_ASSERT_SAME(a_load_free, load, !out_vld_ff,
      "result register overwritten before it was taken")

endmodule

`default_nettype wire
